/* hdl/rrs_pkg.sv */
// Package for the round-robin process scheduler.
// Holds the function and status codes and the ready-queue command struct; no dependencies.
package rrs_pkg;

  typedef enum logic [1:0] {
    FUNC_SELECT = 2'd0,
    FUNC_ADD    = 2'd1,
    FUNC_CREATE = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic pop;
    logic push;
  } fifo_cmd_t;

endpackage

/* hdl/rrs_ready_fifo.sv */
// Circular queue of ready slot numbers with head, tail and fill count.
// Depends on rrs_pkg for the command struct.
module rrs_ready_fifo
  import rrs_pkg::*;
#(
  parameter int MAX_PROCS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fifo_cmd_t                      cmd_i,
  input  logic [$clog2(MAX_PROCS)-1:0]   push_id_i,
  output logic [$clog2(MAX_PROCS)-1:0]   head_id_o,
  output logic [$clog2(MAX_PROCS+1)-1:0] count_o
);

  localparam int IdW  = $clog2(MAX_PROCS);
  localparam int CntW = $clog2(MAX_PROCS + 1);
  localparam logic [IdW-1:0] LastPtr = IdW'(MAX_PROCS - 1);

  logic [IdW-1:0]  mem_q [MAX_PROCS];
  logic [IdW-1:0]  head_q, head_d;
  logic [IdW-1:0]  tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (cmd_i.pop) begin
      head_d = (head_q == LastPtr) ? '0 : head_q + IdW'(1);
    end
    if (cmd_i.push) begin
      tail_d = (tail_q == LastPtr) ? '0 : tail_q + IdW'(1);
    end
    if (cmd_i.push && !cmd_i.pop) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.pop && !cmd_i.push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[tail_q] <= push_id_i;
    end
  end

  assign head_id_o = mem_q[head_q];
  assign count_o   = count_q;

endmodule

/* hdl/rrs_sp_table.sv */
// Saved stack pointer table, one entry per process slot.
// One write port and one combinational read port; no package dependencies.
module rrs_sp_table #(
  parameter int MAX_PROCS = 8,
  parameter int SP_BITS   = 16
) (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic [$clog2(MAX_PROCS)-1:0] wr_addr_i,
  input  logic [SP_BITS-1:0]           wr_data_i,
  input  logic [$clog2(MAX_PROCS)-1:0] rd_addr_i,
  output logic [SP_BITS-1:0]           rd_data_o
);

  logic [SP_BITS-1:0] sp_q [MAX_PROCS];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      sp_q[wr_addr_i] <= wr_data_i;
    end
  end

  assign rd_data_o = sp_q[rd_addr_i];

endmodule

/* hdl/round_robin_process_scheduler.sv */
// Round-robin process scheduler: ready queue, saved stack pointers and running slot.
// Items pass from the input register to the result register, one item per cycle while the
// result side does not stall. The rate is set by the single pass from the input register
// through queue and table to the result register, with all scheduler state updated in the same edge.
// Reset clears queue pointers, fill count, slot count and the running slot; the pointer table
// and queue entries are undefined until written. Uses rrs_pkg, rrs_ready_fifo, rrs_sp_table.
module round_robin_process_scheduler
  import rrs_pkg::*;
#(
  parameter int MAX_PROCS = 8,
  parameter int SP_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] cur_sp_i,
  input  logic        cur_waiting_i,
  input  logic [2:0]  proc_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] next_sp_o,
  output logic [2:0]  run_id_o,
  output logic        run_valid_o,
  output logic [2:0]  new_id_o,
  output logic [1:0]  status_o
);

  localparam int IdW  = $clog2(MAX_PROCS);
  localparam int CntW = $clog2(MAX_PROCS + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(MAX_PROCS);

  // Input register. The item waits here until the result register is free; the pass from
  // here to the result register also commits every state change of the item.
  logic        in_valid_q;
  logic [1:0]  func_q;
  logic [15:0] cur_sp_q;
  logic        waiting_q;
  logic [2:0]  proc_q;
  logic        advance;
  logic        out_valid_q;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      func_q    <= func_i;
      cur_sp_q  <= cur_sp_i;
      waiting_q <= cur_waiting_i;
      proc_q    <= proc_id_i;
    end
  end

  // Stack pointer as stored: the incoming 16 bits cut or zero-extended to SP_BITS.
  logic [SP_BITS+15:0] sp_in_ext;
  logic [SP_BITS-1:0]  sp;
  assign sp_in_ext = {{SP_BITS{1'b0}}, cur_sp_q};
  assign sp        = sp_in_ext[SP_BITS-1:0];

  // Requested slot for add, reduced to the index width after the range check.
  logic [IdW+2:0] pid_ext;
  logic [IdW-1:0] pid_idx;
  assign pid_ext = {{IdW{1'b0}}, proc_q};
  assign pid_idx = pid_ext[IdW-1:0];

  // Scheduler state kept in this module.
  logic [IdW-1:0]  run_slot_q, run_slot_d;
  logic            run_valid_q, run_valid_d;
  logic [CntW-1:0] slots_q, slots_d;

  // Queue and table connections.
  fifo_cmd_t          fifo_cmd;
  logic [IdW-1:0]     push_id;
  logic [IdW-1:0]     head_id;
  logic [CntW-1:0]    fifo_count;
  logic               tbl_wr_en;
  logic [IdW-1:0]     tbl_wr_addr;
  logic [SP_BITS-1:0] tbl_rd_data;

  rrs_ready_fifo #(
    .MAX_PROCS(MAX_PROCS)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (fifo_cmd),
    .push_id_i(push_id),
    .head_id_o(head_id),
    .count_o  (fifo_count)
  );

  // The table is read at the queue head, the slot a select would resume.
  rrs_sp_table #(
    .MAX_PROCS(MAX_PROCS),
    .SP_BITS  (SP_BITS)
  ) u_table (
    .clk_i    (clk_i),
    .wr_en_i  (tbl_wr_en),
    .wr_addr_i(tbl_wr_addr),
    .wr_data_i(sp),
    .rd_addr_i(head_id),
    .rd_data_o(tbl_rd_data)
  );

  // Per-function decisions. Every state change is qualified by advance, so that an item
  // waiting on a stalled output changes nothing until it really moves on.
  logic               do_pop, do_push, do_wr;
  logic               cur;
  logic [SP_BITS-1:0] next_sp;
  logic [IdW-1:0]     new_id;
  status_e            status;

  always_comb begin
    do_pop      = 1'b0;
    do_push     = 1'b0;
    do_wr       = 1'b0;
    push_id     = run_slot_q;
    tbl_wr_addr = run_slot_q;
    run_slot_d  = run_slot_q;
    run_valid_d = run_valid_q;
    slots_d     = slots_q;
    next_sp     = sp;
    new_id      = '0;
    status      = ST_OK;
    cur         = run_valid_q && (sp != '0);
    case (func_e'(func_q))
      FUNC_SELECT: begin
        if (fifo_count == '0) begin
          status = ST_EMPTY;
        end else begin
          // Save a running nonzero pointer, pop the head, and requeue that slot behind it unless it waits.
          do_wr       = cur;
          do_pop      = 1'b1;
          do_push     = cur && !waiting_q;
          run_slot_d  = head_id;
          run_valid_d = 1'b1;
          // The table read sees the old contents, so a slot resumed in the same pass
          // that saves it takes the pointer being saved.
          next_sp     = (cur && (head_id == run_slot_q)) ? sp : tbl_rd_data;
        end
      end
      FUNC_ADD: begin
        if ((fifo_count == CntFull) || (32'(proc_q) >= 32'(MAX_PROCS))) begin
          status = ST_FULL;
        end else begin
          do_push = 1'b1;
          push_id = pid_idx;
        end
      end
      FUNC_CREATE: begin
        if ((slots_q == CntFull) || (fifo_count == CntFull)) begin
          status = ST_FULL;
        end else begin
          do_wr       = 1'b1;
          tbl_wr_addr = slots_q[IdW-1:0];
          do_push     = 1'b1;
          push_id     = slots_q[IdW-1:0];
          slots_d     = slots_q + CntW'(1);
          new_id      = slots_q[IdW-1:0];
        end
      end
      default: begin
        // No operation: the pointer is echoed and nothing changes.
        status = ST_OK;
      end
    endcase
  end

  assign fifo_cmd.pop  = advance && do_pop;
  assign fifo_cmd.push = advance && do_push;
  assign tbl_wr_en     = advance && do_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_slot_q  <= '0;
      run_valid_q <= 1'b0;
      slots_q     <= '0;
    end else if (advance) begin
      run_slot_q  <= run_slot_d;
      run_valid_q <= run_valid_d;
      slots_q     <= slots_d;
    end
  end

  // Result register.
  logic [SP_BITS-1:0] next_sp_q;
  logic [2:0]         run_id_q;
  logic               run_flag_q;
  logic [2:0]         new_id_q;
  status_e            status_q;
  logic [IdW+2:0]     run_ext;
  logic [IdW+2:0]     new_ext;

  assign run_ext = {3'd0, run_slot_d};
  assign new_ext = {3'd0, new_id};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      next_sp_q  <= next_sp;
      run_id_q   <= run_ext[2:0];
      run_flag_q <= run_valid_d;
      new_id_q   <= new_ext[2:0];
      status_q   <= status;
    end
  end

  logic [SP_BITS+15:0] sp_out_ext;
  assign sp_out_ext = {16'd0, next_sp_q};

  assign out_valid_o = out_valid_q;
  assign next_sp_o   = sp_out_ext[15:0];
  assign run_id_o    = run_id_q;
  assign run_valid_o = run_flag_q;
  assign new_id_o    = new_id_q;
  assign status_o    = status_q;

endmodule

/* tb/rrs_sched_checker.sv */
// Scoreboard for the round-robin process scheduler testbench: watches both channels,
// predicts every result from its own copy of the scheduler state and compares field by field.
// Depends on rrs_pkg for the function and status codes.
module rrs_sched_checker
  import rrs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  func_i,
  input  logic [15:0] cur_sp_i,
  input  logic        cur_waiting_i,
  input  logic [2:0]  proc_id_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] next_sp_i,
  input  logic [2:0]  run_id_i,
  input  logic        run_valid_i,
  input  logic [2:0]  new_id_i,
  input  logic [1:0]  status_i,
  output int          fail_count_o,
  output int          awaited_count_o,
  output logic [3:0]  slots_created_o
);

  localparam int NUM_SLOTS = 8;

  typedef struct packed {
    logic [15:0] next_sp;
    logic [2:0]  run_id;
    logic        run_valid;
    logic [2:0]  new_id;
    status_e     status;
  } sched_result_t;

  // Shadow copy of the scheduler state.
  logic [15:0]   sp_table [NUM_SLOTS];
  logic [2:0]    ready_ring [NUM_SLOTS];
  logic [2:0]    ring_head;
  logic [2:0]    ring_tail;
  int            ring_fill;
  logic [2:0]    cur_slot;
  logic          cur_slot_valid;
  int            slots_taken;
  sched_result_t awaited_results [$];
  int            mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic flag_mismatch(string msg);
    $display("[%0t] scheduler check: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) begin
      flag_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  function automatic void ring_push(logic [2:0] slot);
    ready_ring[ring_tail] = slot;
    ring_tail = ring_tail + 3'd1;
    ring_fill++;
  endfunction

  // Applies one item to the shadow state and returns the result it must produce.
  function automatic sched_result_t schedule_item(func_e fn, logic [15:0] sp, logic waits,
                                                  logic [2:0] slot);
    sched_result_t res;
    logic          save_cur;
    logic [2:0]    head_slot;
    res.next_sp = sp;
    res.new_id  = '0;
    res.status  = ST_OK;
    case (fn)
      FUNC_SELECT: begin
        if (ring_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          save_cur = cur_slot_valid && (sp != '0);
          if (save_cur) sp_table[cur_slot] = sp;
          // The head leaves before the running slot goes back, so a full ring cannot overflow.
          head_slot = ready_ring[ring_head];
          ring_head = ring_head + 3'd1;
          ring_fill--;
          if (save_cur && !waits) ring_push(cur_slot);
          cur_slot       = head_slot;
          cur_slot_valid = 1'b1;
          res.next_sp    = sp_table[head_slot];
        end
      end
      FUNC_ADD: begin
        if (ring_fill >= NUM_SLOTS || slot >= NUM_SLOTS) res.status = ST_FULL;
        else ring_push(slot);
      end
      FUNC_CREATE: begin
        if (slots_taken >= NUM_SLOTS || ring_fill >= NUM_SLOTS) begin
          res.status = ST_FULL;
        end else begin
          sp_table[slots_taken] = sp;
          ring_push(3'(slots_taken));
          res.new_id = 3'(slots_taken);
          slots_taken++;
        end
      end
      default: ;
    endcase
    res.run_id    = cur_slot;
    res.run_valid = cur_slot_valid;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t want;
    if (!rst_ni) begin
      ring_head      = '0;
      ring_tail      = '0;
      ring_fill      = 0;
      cur_slot       = '0;
      cur_slot_valid = 1'b0;
      slots_taken    = 0;
      awaited_results.delete();
      awaited_count_o <= 0;
      slots_created_o <= '0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        awaited_results.push_back(schedule_item(func_e'(func_i), cur_sp_i, cur_waiting_i,
                                                proc_id_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          flag_mismatch("result arrived with no item waiting for it");
        end else begin
          want = awaited_results.pop_front();
          check_field("next_sp", next_sp_i, want.next_sp);
          check_field("run_id", run_id_i, want.run_id);
          check_field("run_valid", run_valid_i, want.run_valid);
          check_field("new_id", new_id_i, want.new_id);
          check_field("status", status_i, want.status);
        end
      end
      awaited_count_o <= awaited_results.size();
      slots_created_o <= 4'(slots_taken);
    end
  end

endmodule

/* tb/tb_round_robin_process_scheduler.sv */
// Top of the round-robin process scheduler testbench: clock, reset, stimulus and verdict.
// Depends on rrs_pkg, the scheduler RTL and the rrs_sched_checker scoreboard.
module tb_round_robin_process_scheduler;
  import rrs_pkg::*;

  // The slowest correct run is far below this: about 1830 items, each with at most one
  // sender gap and a few receiver stall bursts.
  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_ITEMS = 1800;
  // The last items go through with no idling on either side.
  localparam int CALM_ITEMS   = 250;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  func_e       func        = FUNC_NOP;
  logic [15:0] cur_sp      = '0;
  logic        cur_waiting = 1'b0;
  logic [2:0]  proc_id     = '0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [15:0] next_sp;
  logic [2:0]  run_id;
  logic        run_valid;
  logic [2:0]  new_id;
  logic [1:0]  status;

  int          fail_count;
  int          awaited_count;
  logic [3:0]  slots_created;
  int          idle_pct    = 0;
  bit          calm        = 1'b0;
  int          cycle_count = 0;
  int          stall_left  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  round_robin_process_scheduler u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .func_i       (func),
    .cur_sp_i     (cur_sp),
    .cur_waiting_i(cur_waiting),
    .proc_id_i    (proc_id),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .next_sp_o    (next_sp),
    .run_id_o     (run_id),
    .run_valid_o  (run_valid),
    .new_id_o     (new_id),
    .status_o     (status)
  );

  rrs_sched_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .func_i         (func),
    .cur_sp_i       (cur_sp),
    .cur_waiting_i  (cur_waiting),
    .proc_id_i      (proc_id),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .next_sp_i      (next_sp),
    .run_id_i       (run_id),
    .run_valid_i    (run_valid),
    .new_id_i       (new_id),
    .status_i       (status),
    .fail_count_o   (fail_count),
    .awaited_count_o(awaited_count),
    .slots_created_o(slots_created)
  );

  // Result side back-pressure: a burst with ready low starts now and then,
  // at a rate set by the current idling phase, and never during the calm tail of the run.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
      stall_left <= $urandom_range(0, 3);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("** round_robin_process_scheduler: FAILED **");
      $finish;
    end
  end

  // Offers one item and returns at the edge where it is taken. It may first drop valid for
  // a short gap; valid is only ever lowered here, before the item is raised, so valid and the
  // fields stay put from the moment they are offered until the item is accepted.
  task automatic send_item(func_e fn, logic [15:0] sp, logic waits, logic [2:0] slot);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= fn;
    cur_sp      <= sp;
    cur_waiting <= waits;
    proc_id     <= slot;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stack pointers lean toward zero and all-ones, since zero means no running process on
  // a select and both ends are worth hitting on create.
  function automatic logic [15:0] pick_sp();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return 16'h0000;
    if (roll < 25) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  initial begin
    int roll;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening. A select on an empty queue and a no-op come first, then two
    // creates, one of them with a zero initial pointer.
    send_item(FUNC_SELECT, 16'hFFFF, 1'b1, 3'd0);
    send_item(FUNC_NOP,    16'h1234, 1'b1, 3'd7);
    send_item(FUNC_CREATE, 16'h0000, 1'b0, 3'd0);
    send_item(FUNC_CREATE, 16'hFFFF, 1'b1, 3'd7);
    // Duplicate adds of both slots fill the queue; one more add and a create are refused.
    repeat (3) begin
      send_item(FUNC_ADD, 16'h0000, 1'b0, 3'd0);
      send_item(FUNC_ADD, 16'hFFFF, 1'b1, 3'd1);
    end
    send_item(FUNC_ADD,    16'h0F0F, 1'b0, 3'd1);
    send_item(FUNC_CREATE, 16'h5555, 1'b0, 3'd0);
    // The first select has nothing running, so nothing is saved or requeued.
    send_item(FUNC_SELECT, 16'hAAAA, 1'b0, 3'd0);
    // With the queue full again, a select that requeues the running slot must pop first.
    send_item(FUNC_ADD,    16'h0000, 1'b0, 3'd0);
    send_item(FUNC_SELECT, 16'h8001, 1'b0, 3'd0);
    // A zero pointer means no save and no requeue; a waiting process is saved, not requeued.
    send_item(FUNC_SELECT, 16'h0000, 1'b0, 3'd0);
    send_item(FUNC_SELECT, 16'h7FFE, 1'b1, 3'd0);
    // Drain the queue with waiting processes, then select on the empty queue while a
    // process runs, which must ignore the waiting flag.
    repeat (6) send_item(FUNC_SELECT, 16'h0001, 1'b1, 3'd0);
    send_item(FUNC_SELECT, 16'hC3C3, 1'b0, 3'd0);
    send_item(FUNC_NOP,    16'hFFFF, 1'b0, 3'd0);

    // Random part. Adds only name slots that already exist, so a select never pops a slot
    // whose saved pointer was never written. The created count seen here may lag by an item,
    // which only makes the choice more cautious.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ((n / 150) % 3)
        0:       idle_pct = 25;
        1:       idle_pct = 0;
        default: idle_pct = 10;
      endcase
      calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
      roll = $urandom_range(0, 99);
      if (roll < 30 && slots_created != 0) begin
        send_item(FUNC_ADD, 16'($urandom), 1'($urandom_range(0, 1)),
                  3'($urandom_range(0, slots_created - 1)));
      end else if (roll < 45) begin
        send_item(FUNC_CREATE, pick_sp(), 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
      end else if (roll < 92) begin
        send_item(FUNC_SELECT, pick_sp(), 1'($urandom_range(0, 99) < 30),
                  3'($urandom_range(0, 7)));
      end else begin
        send_item(FUNC_NOP, 16'($urandom), 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
      end
    end
    in_valid <= 1'b0;

    // Let the scoreboard catch up with the last item, wait until every expected result has
    // come, and leave time for anything stray. The watchdog bounds the wait.
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (fail_count == 0 && awaited_count == 0) begin
      $display("** round_robin_process_scheduler: PASSED **");
    end else begin
      $display("** round_robin_process_scheduler: FAILED **");
    end
    $finish;
  end

endmodule
